FILE: design/canrxrb_pkg.sv
// Package for the CAN receive frame ring buffer.
// Holds the transaction structs, status-word masks and the header packing helper.
// No dependencies.
`default_nettype none

package canrxrb_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [31:0] STATUS_LENGTH_MASK   = 32'h000F_0000;
  localparam logic [31:0] STATUS_REMOTE_MASK   = 32'h4000_0000;
  localparam logic [31:0] STATUS_EXTENDED_MASK = 32'h8000_0000;

  localparam int HEADER_W  = 35;
  localparam int PAYLOAD_W = 64;
  localparam int FILL_W    = 5;

  typedef struct packed {
    logic        operation;
    logic [31:0] frame_status;
    logic [28:0] frame_identifier;
    logic [31:0] payload_low;
    logic [31:0] payload_high;
  } in_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [3:0]  data_length;
    logic        remote_flag;
    logic        extended_flag;
    logic [28:0] identifier;
    logic [31:0] data_first;
    logic [31:0] data_second;
    logic [4:0]  fill_level;
    logic        overwrote_oldest;
    logic        underflow;
  } out_item_t;

  // stored frame header: length, remote, extended, identifier
  typedef struct packed {
    logic [3:0]  data_length;
    logic        remote_flag;
    logic        extended_flag;
    logic [28:0] identifier;
  } header_t;

  // per-transaction status from the ring control
  typedef struct packed {
    logic        frame_valid;
    logic        overwrote_oldest;
    logic        underflow;
    logic [4:0]  fill_level;
  } step_status_t;

  function automatic header_t pack_header(input logic [31:0] status,
                                          input logic [28:0] raw_id);
    header_t h;
    logic [31:0] len_bits;
    len_bits        = (status & STATUS_LENGTH_MASK) >> 16;
    h.data_length   = len_bits[3:0];
    h.remote_flag   = (status & STATUS_REMOTE_MASK) != 32'd0;
    h.extended_flag = (status & STATUS_EXTENDED_MASK) != 32'd0;
    // standard frames keep only the 11-bit identifier
    h.identifier    = h.extended_flag ? raw_id : {18'd0, raw_id[10:0]};
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: design/canrxrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the header and payload stores. No dependencies.
`default_nettype none

module canrxrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/canrxrb_ctrl.sv
// Ring control for the CAN receive frame buffer: read pointer, fill count,
// slot addressing and per-transaction status. Depends on canrxrb_pkg.
`default_nettype none

module canrxrb_ctrl #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic                         operation,
  output logic                              wr_en,
  output logic [$clog2(DEPTH)-1:0]          wr_addr,
  output logic                              rd_en,
  output logic [$clog2(DEPTH)-1:0]          rd_addr,
  output canrxrb_pkg::step_status_t         status_nxt
);

  import canrxrb_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C    = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S    = SW'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);

  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] slot_sum;
  logic [PW-1:0] ptr_inc;
  logic          full, empty;
  logic [CW+4:0] fill_ext;

  assign full     = fill_r == DEPTH_C;
  assign empty    = fill_r == '0;
  assign ptr_inc  = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
  assign slot_sum = SW'(rd_ptr_r) + SW'(fill_r);

  // slot after the newest frame; equals the oldest slot when full
  assign wr_addr = (slot_sum >= DEPTH_S) ? PW'(slot_sum - DEPTH_S) : PW'(slot_sum);
  assign rd_addr = rd_ptr_r;
  assign wr_en   = accept && (operation == OP_PUSH);
  assign rd_en   = accept && (operation == OP_POP) && !empty;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    status_nxt = '0;
    if (operation == OP_PUSH) begin
      if (full) begin
        rd_ptr_nxt                  = ptr_inc;
        status_nxt.overwrote_oldest = 1'b1;
      end else begin
        fill_nxt = fill_r + CW'(1);
      end
    end else begin
      if (empty) begin
        status_nxt.underflow = 1'b1;
      end else begin
        rd_ptr_nxt             = ptr_inc;
        fill_nxt               = fill_r - CW'(1);
        status_nxt.frame_valid = 1'b1;
      end
    end
    fill_ext              = (CW + 5)'(fill_nxt);
    status_nxt.fill_level = fill_ext[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else if (accept) begin
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/can_rx_frame_ring_buffer.sv
// Top level of the CAN receive frame ring buffer.
// Depends on canrxrb_pkg, canrxrb_ctrl and canrxrb_ram.
//
// Overwriting receive queue of BUFFER_DEPTH CAN frames. Each transaction is a
// push (raw status word, identifier, two data words) or a pop, and produces
// exactly one result in the cycle after acceptance; a new transaction can be
// accepted every cycle, and in_stall rises only while a result is held by
// out_stall. The result comes from the registered read of the frame stores.
// A push on a full ring replaces the oldest frame and flags it; a pop on an
// empty ring flags underflow and changes nothing. Every result carries the
// fill level after the step. Stores are not cleared at reset; only written
// slots are ever popped.
`default_nettype none

module can_rx_frame_ring_buffer #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire canrxrb_pkg::in_item_t in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output canrxrb_pkg::out_item_t     out_item
);

  import canrxrb_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);

  logic                 accept;
  logic                 wr_en, rd_en;
  logic [PW-1:0]        wr_addr, rd_addr;
  step_status_t         status_nxt, status_r;
  logic                 out_valid_r, out_valid_nxt;
  header_t              hdr_wr, hdr_rd;
  logic [HEADER_W-1:0]  hdr_rd_bits;
  logic [PAYLOAD_W-1:0] pay_rd;

  // result register frees as it is taken, so stall only while it is held
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign hdr_wr = pack_header(in_item.frame_status, in_item.frame_identifier);

  canrxrb_ctrl #(
    .DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_item.operation),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .status_nxt(status_nxt)
  );

  canrxrb_ram #(
    .WIDTH(HEADER_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_header_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(hdr_wr),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(hdr_rd_bits)
  );

  canrxrb_ram #(
    .WIDTH(PAYLOAD_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_payload_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data({in_item.payload_high, in_item.payload_low}),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(pay_rd)
  );

  assign hdr_rd = hdr_rd_bits;

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  // frame fields read as zero unless a stored frame was popped
  always_comb begin
    out_item                  = '0;
    out_item.frame_valid      = status_r.frame_valid;
    out_item.fill_level       = status_r.fill_level;
    out_item.overwrote_oldest = status_r.overwrote_oldest;
    out_item.underflow        = status_r.underflow;
    if (status_r.frame_valid) begin
      out_item.data_length   = hdr_rd.data_length;
      out_item.remote_flag   = hdr_rd.remote_flag;
      out_item.extended_flag = hdr_rd.extended_flag;
      out_item.identifier    = hdr_rd.identifier;
      out_item.data_first    = pay_rd[31:0];
      out_item.data_second   = pay_rd[63:32];
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: verif/tb_can_rx_frame_ring_buffer.sv
// Self-checking testbench for the CAN receive frame ring buffer.
// Predicts every push and pop on a private copy of the ring and compares each result.
// Depends on canrxrb_pkg and can_rx_frame_ring_buffer.
`default_nettype none

module tb_can_rx_frame_ring_buffer;
  import canrxrb_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS_PER_PHASE = 575;

  class can_rx_ring_scoreboard;
    header_t     headers [RING_DEPTH];
    logic [63:0] payloads [RING_DEPTH];
    int          oldest;
    int          held;
    int          mismatches;
    out_item_t   expected_results [$];

    function new();
      oldest     = 0;
      held       = 0;
      mismatches = 0;
    endfunction

    // work out the single result that an accepted transaction causes
    function void note_transaction(in_item_t it);
      out_item_t res;
      header_t   hdr;
      int        slot;
      res = '0;
      if (it.operation == OP_PUSH) begin
        hdr.data_length   = it.frame_status[19:16];
        hdr.remote_flag   = it.frame_status[30];
        hdr.extended_flag = it.frame_status[31];
        hdr.identifier    = hdr.extended_flag ? it.frame_identifier
                                              : {18'd0, it.frame_identifier[10:0]};
        slot = (oldest + held) % RING_DEPTH;
        headers[slot]  = hdr;
        payloads[slot] = {it.payload_high, it.payload_low};
        if (held == RING_DEPTH) begin
          // full ring: newest frame lands on the oldest one
          oldest = (oldest + 1) % RING_DEPTH;
          res.overwrote_oldest = 1'b1;
        end else begin
          held++;
        end
      end else if (held == 0) begin
        res.underflow = 1'b1;
      end else begin
        hdr               = headers[oldest];
        res.frame_valid   = 1'b1;
        res.data_length   = hdr.data_length;
        res.remote_flag   = hdr.remote_flag;
        res.extended_flag = hdr.extended_flag;
        res.identifier    = hdr.identifier;
        res.data_first    = payloads[oldest][31:0];
        res.data_second   = payloads[oldest][63:32];
        oldest = (oldest + 1) % RING_DEPTH;
        held--;
      end
      res.fill_level = 5'(held);
      expected_results.push_back(res);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) report($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing outstanding: %h", got));
        return;
      end
      want = expected_results.pop_front();
      compare_field("frame_valid", 32'(want.frame_valid), 32'(got.frame_valid));
      compare_field("data_length", 32'(want.data_length), 32'(got.data_length));
      compare_field("remote_flag", 32'(want.remote_flag), 32'(got.remote_flag));
      compare_field("extended_flag", 32'(want.extended_flag), 32'(got.extended_flag));
      compare_field("identifier", 32'(want.identifier), 32'(got.identifier));
      compare_field("data_first", want.data_first, got.data_first);
      compare_field("data_second", want.data_second, got.data_second);
      compare_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
      compare_field("overwrote_oldest", 32'(want.overwrote_oldest),
                    32'(got.overwrote_oldest));
      compare_field("underflow", 32'(want.underflow), 32'(got.underflow));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (expected_results.size() == 0);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests = 0;
  int holds_served  = 0;

  can_rx_ring_scoreboard board = new();

  can_rx_frame_ring_buffer #(
    .BUFFER_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // values read here are the ones held before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_item);
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  function automatic in_item_t frame(logic op, logic [31:0] status, logic [28:0] id,
                                     logic [31:0] lo, logic [31:0] hi);
    in_item_t it;
    it.operation        = op;
    it.frame_status     = status;
    it.frame_identifier = id;
    it.payload_low      = lo;
    it.payload_high     = hi;
    return it;
  endfunction

  function automatic in_item_t random_frame(int push_pct);
    in_item_t it;
    it = frame(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, $urandom,
               29'($urandom), $urandom, $urandom);
    case ($urandom_range(0, 15))
      0: it.frame_status = '0;
      1: it.frame_status = '1;
      2: it.frame_identifier = '1;
      3: it.frame_identifier = '0;
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_frame(in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_transaction(it);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int push_pct;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    tx_idle_pct = 33;
    rx_idle_pct = 50;
    push_pct    = 50;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // pop on an empty ring
    send_frame(frame(OP_POP, '0, '0, '0, '0));
    // standard frame with all identifier bits set, upper ones must be dropped
    send_frame(frame(OP_PUSH, 32'h7FFF_FFFF, '1, '1, '1));
    send_frame(frame(OP_PUSH, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, '0));
    send_frame(frame(OP_PUSH, '0, '0, '0, 32'hFFFF_FFFF));
    repeat (4) send_frame(frame(OP_POP, '1, '1, '1, '1));
    // seventeen pushes from empty: the last one overwrites the oldest
    for (n = 0; n < RING_DEPTH + 1; n++) begin
      send_frame(frame(OP_PUSH, $urandom, 29'($urandom), $urandom, $urandom));
    end

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 50 : 0;
      rx_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 33 : 0;
      for (n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
        // bias swings so the fill level sweeps between empty and full
        if (n % 40 == 0) begin
          case ($urandom_range(0, 3))
            0: push_pct = 20;
            1: push_pct = 50;
            2: push_pct = 65;
            default: push_pct = 85;
          endcase
        end
        if (phase == 0 && n == 200) hold_requests++;
        if (phase == 1 && n == 300) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (board.pending() != 0) @(posedge clk);
        end
        send_frame(random_frame(push_pct));
      end
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.clean()) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
